FILE: design/assert_macros.svh
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// cond holds at every clock edge outside reset
`define TCUR_ASSERT(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// ante at one edge implies cons at the same edge
`define TCUR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// ante at one edge implies cons at the next edge
`define TCUR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TCUR_ASSERT(label, clk, rst, cond, msg)
`define TCUR_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define TCUR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: design/tcur_pkg.sv
`timescale 1ns / 1ps
package tcur_pkg;

  localparam int ROW_BITS       = 20;
  localparam int COLUMN_BITS    = 16;
  localparam int START_ROW_BITS = 20;
  localparam int START_COL_BITS = 16;
  localparam int TAB_BITS       = 8;
  localparam int DIV_CNT_BITS   = $clog2(COLUMN_BITS);

  localparam int FIFO_DEPTH     = 2;
  localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);

  localparam int APB_ADDR_BITS  = 4;
  localparam int APB_DATA_BITS  = 32;

  localparam logic [32:0] ROW_MAX_W = (33'd1 << ROW_BITS) - 33'd1;
  localparam logic [32:0] COL_MAX_W = (33'd1 << COLUMN_BITS) - 33'd1;

  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_LF  = 8'h0a;
  localparam logic [7:0] CHAR_CR  = 8'h0d;
  localparam logic [7:0] CHAR_EF  = 8'hef;
  localparam logic [7:0] CHAR_BB  = 8'hbb;
  localparam logic [7:0] CHAR_BE  = 8'hbe;
  localparam logic [7:0] CHAR_BF  = 8'hbf;

  localparam logic [TAB_BITS-1:0]       TAB_SIZE_RST     = 8'd4;
  localparam logic                      ENCODING_RST     = 1'b1;
  localparam logic [START_ROW_BITS-1:0] START_ROW_RST    = '0;
  localparam logic [START_COL_BITS-1:0] START_COLUMN_RST = '0;

  // pending line-break pair codes
  localparam logic [1:0] PAIR_NONE    = 2'd0;
  localparam logic [1:0] PAIR_WANT_LF = 2'd1;
  localparam logic [1:0] PAIR_WANT_CR = 2'd2;

  typedef enum logic [1:0] {
    REG_TAB_SIZE     = 2'd0,
    REG_ENCODING     = 2'd1,
    REG_START_ROW    = 2'd2,
    REG_START_COLUMN = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    BC_ZERO  = 3'd0,
    BC_CR    = 3'd1,
    BC_LF    = 3'd2,
    BC_TAB   = 3'd3,
    BC_EF    = 3'd4,
    BC_PLAIN = 3'd5
  } byte_class_t;

  typedef struct packed {
    logic        restart;
    byte_class_t cls;
    logic [1:0]  skip_len;
    logic [7:0]  data;
  } cmd_t;

  typedef struct packed {
    logic [TAB_BITS-1:0]       tab_size;
    logic [START_ROW_BITS-1:0] start_row;
    logic [START_COL_BITS-1:0] start_column;
  } cfg_t;

  function automatic logic [ROW_BITS-1:0] row_load(input logic [START_ROW_BITS-1:0] v);
    logic [32:0] w;
    w = 33'(v);
    if (w > ROW_MAX_W) begin
      w = ROW_MAX_W;
    end
    return ROW_BITS'(w);
  endfunction

  function automatic logic [COLUMN_BITS-1:0] col_load(input logic [START_COL_BITS-1:0] v);
    logic [32:0] w;
    w = 33'(v);
    if (w > COL_MAX_W) begin
      w = COL_MAX_W;
    end
    return COLUMN_BITS'(w);
  endfunction

endpackage

FILE: design/text_cursor_row_column_tracker_unit.sv
`timescale 1ns / 1ps
// text cursor tracker: each accepted input word (a text byte or a restart) yields one
// result word with the row, column and halt flag after that word. CR or LF opens a new
// row (CR-LF and LF-CR count once), tab moves to the next multiple of tab_size, UTF-8
// multibyte characters count one column and EF BB BF / EF BF BE / EF BF BF count none,
// a zero byte halts until restart, tab_size 0 freezes the cursor. row and column
// saturate. a front stage classifies bytes into a 2-word queue; the back stage applies
// them. a restart or non-tab byte is applied in the run state; a tab also passes through
// the divide and finish states, because the remainder column mod tab_size comes from a
// bit-serial divider, one bit per cycle. with the result register free, the front takes
// one word per cycle until the queue fills. config registers over APB at 0x0 tab_size,
// 0x4 encoding_utf8, 0x8 start_row, 0xc start_column; write only while idle
module text_cursor_row_column_tracker_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  // apb config port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [tcur_pkg::APB_ADDR_BITS-1:0]    paddr,
  input  logic [tcur_pkg::APB_DATA_BITS-1:0]    pwdata,
  output logic [tcur_pkg::APB_DATA_BITS-1:0]    prdata,
  output logic                                  pready,
  // input word channel
  input  logic                                  item_valid,
  output logic                                  item_ready,
  input  logic                                  action,
  input  logic [7:0]                            data_byte,
  // result word channel
  output logic                                  result_valid,
  input  logic                                  result_ready,
  output logic [tcur_pkg::ROW_BITS-1:0]         cursor_row,
  output logic [tcur_pkg::COLUMN_BITS-1:0]      cursor_column,
  output logic                                  halted
);

  // config registers
  logic [tcur_pkg::TAB_BITS-1:0]       tab_size;
  logic                                encoding_utf8;
  logic [tcur_pkg::START_ROW_BITS-1:0] start_row;
  logic [tcur_pkg::START_COL_BITS-1:0] start_column;

  tcur_pkg::reg_index_t reg_sel;
  logic                 cfg_write;
  tcur_pkg::cfg_t       cfg;

  // queue between front and back
  logic           q_push;
  logic           q_full;
  tcur_pkg::cmd_t q_push_cmd;
  logic           q_pop;
  logic           q_valid;
  tcur_pkg::cmd_t q_cmd;

  assign pready    = 1'b1;
  assign reg_sel   = tcur_pkg::reg_index_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tab_size      <= tcur_pkg::TAB_SIZE_RST;
      encoding_utf8 <= tcur_pkg::ENCODING_RST;
      start_row     <= tcur_pkg::START_ROW_RST;
      start_column  <= tcur_pkg::START_COLUMN_RST;
    end else if (cfg_write) begin
      case (reg_sel)
        tcur_pkg::REG_TAB_SIZE:     tab_size      <= pwdata[tcur_pkg::TAB_BITS-1:0];
        tcur_pkg::REG_ENCODING:     encoding_utf8 <= pwdata[0];
        tcur_pkg::REG_START_ROW:    start_row     <= pwdata[tcur_pkg::START_ROW_BITS-1:0];
        tcur_pkg::REG_START_COLUMN: start_column  <= pwdata[tcur_pkg::START_COL_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_sel)
      tcur_pkg::REG_TAB_SIZE:     prdata = tcur_pkg::APB_DATA_BITS'(tab_size);
      tcur_pkg::REG_ENCODING:     prdata = tcur_pkg::APB_DATA_BITS'(encoding_utf8);
      tcur_pkg::REG_START_ROW:    prdata = tcur_pkg::APB_DATA_BITS'(start_row);
      tcur_pkg::REG_START_COLUMN: prdata = tcur_pkg::APB_DATA_BITS'(start_column);
      default:                    prdata = '0;
    endcase
  end

  assign cfg.tab_size     = tab_size;
  assign cfg.start_row    = start_row;
  assign cfg.start_column = start_column;

  // front: accept and classify words
  tcur_front u_front (
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .action        (action),
    .data_byte     (data_byte),
    .encoding_utf8 (encoding_utf8),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (q_push_cmd)
  );

  // short decoupling queue
  tcur_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_cmd   (q_cmd)
  );

  // back: cursor state, tab divider, result register
  tcur_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .cursor_row    (cursor_row),
    .cursor_column (cursor_column),
    .halted        (halted)
  );

endmodule

FILE: design/tcur_fifo.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tcur_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tcur_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            pop_valid,
  output tcur_pkg::cmd_t  pop_cmd
);

  tcur_pkg::cmd_t                        entry [tcur_pkg::FIFO_DEPTH];
  logic [tcur_pkg::FIFO_PTR_BITS-1:0]    wr_ptr;
  logic [tcur_pkg::FIFO_PTR_BITS-1:0]    rd_ptr;
  logic [tcur_pkg::FIFO_CNT_BITS-1:0]    count;

  function automatic logic [tcur_pkg::FIFO_CNT_BITS-1:0] FIFO_CNT_ONE(input logic b);
    return tcur_pkg::FIFO_CNT_BITS'(b);
  endfunction

  assign full      = (count == tcur_pkg::FIFO_CNT_BITS'(tcur_pkg::FIFO_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_cmd   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + FIFO_CNT_ONE(push) - FIFO_CNT_ONE(pop);
    end
  end

  `TCUR_ASSERT_IMPL(a_no_overflow, clk, rst, push, !full || pop, "fifo push while full")
  `TCUR_ASSERT_IMPL(a_no_underflow, clk, rst, pop, pop_valid, "fifo pop while empty")
  `TCUR_ASSERT_NEXT(a_count_track, clk, rst, push && !pop, count == $past(count) + 1'b1,
                    "fifo count did not follow push")

endmodule

FILE: design/tcur_front.sv
`timescale 1ns / 1ps
module tcur_front (
  input  logic            item_valid,
  output logic            item_ready,
  input  logic            action,
  input  logic [7:0]      data_byte,
  input  logic            encoding_utf8,
  input  logic            q_full,
  output logic            q_push,
  output tcur_pkg::cmd_t  q_cmd
);

  // continuation bytes that follow a lead byte
  function automatic logic [1:0] follow_count(input logic [7:0] b);
    if (b >= 8'hc2 && b <= 8'hdf) begin
      return 2'd1;
    end
    if (b >= 8'he0 && b <= 8'hef) begin
      return 2'd2;
    end
    if (b >= 8'hf0 && b <= 8'hf4) begin
      return 2'd3;
    end
    return 2'd0;
  endfunction

  assign item_ready = !q_full;
  assign q_push     = item_valid && !q_full;

  always_comb begin
    q_cmd          = '0;
    q_cmd.restart  = action;
    q_cmd.data     = data_byte;
    q_cmd.skip_len = 2'd0;
    if (data_byte == 8'h00) begin
      q_cmd.cls = tcur_pkg::BC_ZERO;
    end else if (data_byte == tcur_pkg::CHAR_CR) begin
      q_cmd.cls = tcur_pkg::BC_CR;
    end else if (data_byte == tcur_pkg::CHAR_LF) begin
      q_cmd.cls = tcur_pkg::BC_LF;
    end else if (data_byte == tcur_pkg::CHAR_TAB) begin
      q_cmd.cls = tcur_pkg::BC_TAB;
    end else if (encoding_utf8 && data_byte == tcur_pkg::CHAR_EF) begin
      q_cmd.cls = tcur_pkg::BC_EF;
    end else begin
      q_cmd.cls = tcur_pkg::BC_PLAIN;
      if (encoding_utf8) begin
        q_cmd.skip_len = follow_count(data_byte);
      end
    end
  end

endmodule

FILE: design/tcur_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tcur_back (
  input  logic                                clk,
  input  logic                                rst,
  input  tcur_pkg::cfg_t                      cfg,
  input  logic                                q_valid,
  input  tcur_pkg::cmd_t                      q_cmd,
  output logic                                q_pop,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic [tcur_pkg::ROW_BITS-1:0]       cursor_row,
  output logic [tcur_pkg::COLUMN_BITS-1:0]    cursor_column,
  output logic                                halted
);

  localparam int CB = tcur_pkg::COLUMN_BITS;
  localparam int TB = tcur_pkg::TAB_BITS;

  typedef enum logic [2:0] {
    ST_RUN = 3'b001,
    ST_DIV = 3'b010,
    ST_FIN = 3'b100
  } state_t;

  state_t                              state, state_next;
  logic [tcur_pkg::ROW_BITS-1:0]       row_count, row_count_next;
  logic [CB-1:0]                       column_count, column_count_next;
  logic [1:0]                          skip_remaining, skip_remaining_next;
  logic [1:0]                          pair_swallow, pair_swallow_next;
  logic                                lead_was_ef, lead_was_ef_next;
  logic [7:0]                          first_follower, first_follower_next;
  logic                                stopped, stopped_next;
  logic                                result_valid_next;
  logic [TB-1:0]                       rem, rem_next;
  logic [CB-1:0]                       dividend, dividend_next;
  logic [tcur_pkg::DIV_CNT_BITS-1:0]   div_cnt, div_cnt_next;

  logic          fire;
  logic          load_result;
  logic          go_div;
  logic          swallowed;
  logic [1:0]    skip_dec;
  logic          zero_width;
  logic [TB:0]   trial;
  logic [CB:0]   tab_stop;
  logic [CB-1:0] col_inc;
  logic [tcur_pkg::ROW_BITS-1:0] row_inc;

  assign cursor_row    = row_count;
  assign cursor_column = column_count;
  assign halted        = stopped;
  assign q_pop         = fire;

  assign fire     = (state == ST_RUN) && q_valid && (!result_valid || result_ready);
  assign skip_dec = skip_remaining - 2'd1;
  assign col_inc  = (&column_count) ? column_count : column_count + 1'b1;
  assign row_inc  = (&row_count) ? row_count : row_count + 1'b1;
  assign zero_width =
      (first_follower == tcur_pkg::CHAR_BB && q_cmd.data == tcur_pkg::CHAR_BF) ||
      (first_follower == tcur_pkg::CHAR_BF &&
       (q_cmd.data == tcur_pkg::CHAR_BE || q_cmd.data == tcur_pkg::CHAR_BF));
  assign swallowed =
      (pair_swallow == tcur_pkg::PAIR_WANT_LF && q_cmd.data == tcur_pkg::CHAR_LF) ||
      (pair_swallow == tcur_pkg::PAIR_WANT_CR && q_cmd.data == tcur_pkg::CHAR_CR);
  assign trial    = {rem, dividend[CB-1]};
  assign tab_stop = {1'b0, column_count} - (CB+1)'(rem) + (CB+1)'(cfg.tab_size);

  always_comb begin
    state_next          = state;
    row_count_next      = row_count;
    column_count_next   = column_count;
    skip_remaining_next = skip_remaining;
    pair_swallow_next   = pair_swallow;
    lead_was_ef_next    = lead_was_ef;
    first_follower_next = first_follower;
    stopped_next        = stopped;
    rem_next            = rem;
    dividend_next       = dividend;
    div_cnt_next        = div_cnt;
    load_result         = 1'b0;
    go_div              = 1'b0;

    case (state)
      ST_RUN: begin
        if (fire) begin
          if (q_cmd.restart) begin
            row_count_next      = tcur_pkg::row_load(cfg.start_row);
            column_count_next   = tcur_pkg::col_load(cfg.start_column);
            skip_remaining_next = 2'd0;
            pair_swallow_next   = tcur_pkg::PAIR_NONE;
            lead_was_ef_next    = 1'b0;
            first_follower_next = 8'h00;
            stopped_next        = 1'b0;
          end else if (cfg.tab_size != '0 && !stopped) begin
            if (q_cmd.cls == tcur_pkg::BC_ZERO) begin
              stopped_next        = 1'b1;
              skip_remaining_next = 2'd0;
              pair_swallow_next   = tcur_pkg::PAIR_NONE;
              lead_was_ef_next    = 1'b0;
            end else if (skip_remaining != 2'd0) begin
              // continuation byte, content ignored except after an EF lead
              skip_remaining_next = skip_dec;
              if (lead_was_ef) begin
                if (skip_dec == 2'd1) begin
                  first_follower_next = q_cmd.data;
                end else if (skip_dec == 2'd0) begin
                  if (!zero_width) begin
                    column_count_next = col_inc;
                  end
                  lead_was_ef_next = 1'b0;
                end
              end
            end else begin
              pair_swallow_next = tcur_pkg::PAIR_NONE;
              if (!swallowed) begin
                case (q_cmd.cls)
                  tcur_pkg::BC_CR, tcur_pkg::BC_LF: begin
                    row_count_next    = row_inc;
                    column_count_next = '0;
                    pair_swallow_next = (q_cmd.cls == tcur_pkg::BC_CR) ?
                                        tcur_pkg::PAIR_WANT_LF : tcur_pkg::PAIR_WANT_CR;
                  end
                  tcur_pkg::BC_TAB: begin
                    go_div = 1'b1;
                  end
                  tcur_pkg::BC_EF: begin
                    skip_remaining_next = 2'd2;
                    lead_was_ef_next    = 1'b1;
                  end
                  default: begin
                    column_count_next   = col_inc;
                    skip_remaining_next = q_cmd.skip_len;
                    lead_was_ef_next    = 1'b0;
                  end
                endcase
              end
            end
          end
          if (go_div) begin
            state_next    = ST_DIV;
            rem_next      = '0;
            dividend_next = column_count;
            div_cnt_next  = tcur_pkg::DIV_CNT_BITS'(CB - 1);
          end else begin
            load_result = 1'b1;
          end
        end
      end
      ST_DIV: begin
        // one remainder bit per cycle, msb first
        if (trial >= {1'b0, cfg.tab_size}) begin
          rem_next = TB'(trial - {1'b0, cfg.tab_size});
        end else begin
          rem_next = trial[TB-1:0];
        end
        dividend_next = {dividend[CB-2:0], 1'b0};
        if (div_cnt == '0) begin
          state_next = ST_FIN;
        end else begin
          div_cnt_next = div_cnt - 1'b1;
        end
      end
      ST_FIN: begin
        column_count_next = tab_stop[CB] ? {CB{1'b1}} : tab_stop[CB-1:0];
        load_result       = 1'b1;
        state_next        = ST_RUN;
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase

    result_valid_next = load_result || (result_valid && !result_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_RUN;
      row_count      <= tcur_pkg::row_load(tcur_pkg::START_ROW_RST);
      column_count   <= tcur_pkg::col_load(tcur_pkg::START_COLUMN_RST);
      skip_remaining <= 2'd0;
      pair_swallow   <= tcur_pkg::PAIR_NONE;
      lead_was_ef    <= 1'b0;
      first_follower <= 8'h00;
      stopped        <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      state          <= state_next;
      row_count      <= row_count_next;
      column_count   <= column_count_next;
      skip_remaining <= skip_remaining_next;
      pair_swallow   <= pair_swallow_next;
      lead_was_ef    <= lead_was_ef_next;
      first_follower <= first_follower_next;
      stopped        <= stopped_next;
      result_valid   <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rem      <= rem_next;
    dividend <= dividend_next;
    div_cnt  <= div_cnt_next;
  end

  `TCUR_ASSERT_IMPL(a_no_result_in_div, clk, rst, state != ST_RUN, !result_valid,
                    "result shown during tab step")
  `TCUR_ASSERT_IMPL(a_halt_clears, clk, rst, stopped,
                    skip_remaining == 2'd0 && pair_swallow == tcur_pkg::PAIR_NONE && !lead_was_ef,
                    "pending state survived halt")
  `TCUR_ASSERT_IMPL(a_ef_needs_skip, clk, rst, lead_was_ef, skip_remaining != 2'd0,
                    "ef lead flag without pending skip")
  `TCUR_ASSERT_NEXT(a_fin_delivers, clk, rst, state == ST_FIN, result_valid && state == ST_RUN,
                    "tab step did not deliver result")

endmodule

FILE: verif/text_cursor_row_column_tracker_unit_test.sv
`timescale 1ns / 1ps
module text_cursor_row_column_tracker_unit_test;
  import tcur_pkg::*;

  // one result word as the block reports it
  typedef struct packed {
    logic [ROW_BITS-1:0]    row;
    logic [COLUMN_BITS-1:0] column;
    logic                   halt;
  } cursor_t;

  localparam logic [ROW_BITS-1:0]    ROW_TOP = {ROW_BITS{1'b1}};
  localparam logic [COLUMN_BITS-1:0] COL_TOP = {COLUMN_BITS{1'b1}};

  logic                     clk;
  logic                     rst;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;
  logic                     item_valid;
  logic                     item_ready;
  logic                     action;
  logic [7:0]               data_byte;
  logic                     result_valid;
  logic                     result_ready;
  logic [ROW_BITS-1:0]      cursor_row;
  logic [COLUMN_BITS-1:0]   cursor_column;
  logic                     halted;

  text_cursor_row_column_tracker_unit uut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .action        (action),
    .data_byte     (data_byte),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .cursor_row    (cursor_row),
    .cursor_column (cursor_column),
    .halted        (halted)
  );

  // shadow copy of the config registers
  logic [TAB_BITS-1:0]       cfg_tab;
  logic                      cfg_utf8;
  logic [START_ROW_BITS-1:0] cfg_row;
  logic [START_COL_BITS-1:0] cfg_col;

  // predicted cursor state
  logic [ROW_BITS-1:0]    cur_row;
  logic [COLUMN_BITS-1:0] cur_col;
  logic [1:0]             skip_left;
  logic [1:0]             pair_pend;
  logic                   ef_lead;
  logic [7:0]             follower;
  logic                   is_halted;

  // predicted result words, oldest first
  cursor_t pending_cursors[$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int words_sent;
  int results_checked;
  int reg_writes;

  // free-running clock, 2 ns period
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop in case a handshake never completes
  initial begin
    #1_000_000;
    $display("text_cursor_row_column_tracker_unit_test failed");
    $finish;
  end

  // ---------------------------------------------------------------
  // cursor predictor
  // ---------------------------------------------------------------

  function automatic void restart_cursor();
    cur_row   = cfg_row;
    cur_col   = cfg_col;
    skip_left = 2'd0;
    pair_pend = PAIR_NONE;
    ef_lead   = 1'b0;
    follower  = 8'h00;
    is_halted = 1'b0;
  endfunction

  function automatic void bump_column();
    if (cur_col != COL_TOP) cur_col = cur_col + 1'b1;
  endfunction

  // number of continuation bytes a lead byte announces
  function automatic logic [1:0] follower_count(logic [7:0] b);
    if (b >= 8'hc2 && b <= 8'hdf) return 2'd1;
    if (b >= 8'he0 && b <= 8'hef) return 2'd2;
    if (b >= 8'hf0 && b <= 8'hf4) return 2'd3;
    return 2'd0;
  endfunction

  function automatic void take_text_byte(logic [7:0] b);
    logic [7:0]  want;
    int unsigned stop;
    // zero byte halts, progress stays, pending skip and pair dropped
    if (b == 8'h00) begin
      is_halted = 1'b1;
      skip_left = 2'd0;
      pair_pend = PAIR_NONE;
      ef_lead   = 1'b0;
      return;
    end
    // continuation bytes, content only matters after an EF lead
    if (skip_left != 2'd0) begin
      skip_left = skip_left - 1'b1;
      if (ef_lead) begin
        if (skip_left == 2'd1) begin
          follower = b;
        end else if (skip_left == 2'd0) begin
          if (!((follower == CHAR_BB && b == CHAR_BF) ||
                (follower == CHAR_BF && (b == CHAR_BE || b == CHAR_BF))))
            bump_column();
          ef_lead = 1'b0;
        end
      end
      return;
    end
    // second half of a CR-LF or LF-CR pair is swallowed
    if (pair_pend != PAIR_NONE) begin
      want = (pair_pend == PAIR_WANT_LF) ? CHAR_LF : CHAR_CR;
      pair_pend = PAIR_NONE;
      if (b == want) return;
    end
    if (b == CHAR_CR || b == CHAR_LF) begin
      if (cur_row != ROW_TOP) cur_row = cur_row + 1'b1;
      cur_col   = '0;
      pair_pend = (b == CHAR_CR) ? PAIR_WANT_LF : PAIR_WANT_CR;
      return;
    end
    if (b == CHAR_TAB) begin
      stop = (int'(cur_col) / int'(cfg_tab) + 1) * int'(cfg_tab);
      cur_col = (stop > int'(COL_TOP)) ? COL_TOP : COLUMN_BITS'(stop);
      return;
    end
    if (!cfg_utf8) begin
      bump_column();
      return;
    end
    // EF lead defers its column until both followers are seen
    if (b == CHAR_EF) begin
      skip_left = 2'd2;
      ef_lead   = 1'b1;
      return;
    end
    bump_column();
    skip_left = follower_count(b);
    ef_lead   = 1'b0;
  endfunction

  function automatic cursor_t advance_cursor(logic act, logic [7:0] b);
    if (act) restart_cursor();
    else if (cfg_tab != '0 && !is_halted) take_text_byte(b);
    return '{cur_row, cur_col, is_halted};
  endfunction

  // ---------------------------------------------------------------
  // shared driving and checking
  // ---------------------------------------------------------------

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0h, got %0h", what, want, got);
    end
  endfunction

  // one word on the input channel, called and returning right after a falling edge
  task automatic send_word(logic act, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    action     <= act;
    data_byte  <= b;
    do @(posedge clk); while (!item_ready);
    pending_cursors.push_back(advance_cursor(act, b));
    words_sent++;
    @(negedge clk);
  endtask

  // hold the input side until every predicted word has come back
  task automatic wait_drained();
    item_valid <= 1'b0;
    while (pending_cursors.size() != 0) @(negedge clk);
    // tab steps keep the divider busy for a while
    repeat (40) @(negedge clk);
  endtask

  // apb write then read back, only while the block is idle
  task automatic cfg_write(reg_index_t idx, logic [31:0] value);
    logic [31:0] mask;
    case (idx)
      REG_TAB_SIZE: begin
        cfg_tab = value[TAB_BITS-1:0];
        mask    = 32'h0000_00ff;
      end
      REG_ENCODING: begin
        cfg_utf8 = value[0];
        mask     = 32'h0000_0001;
      end
      REG_START_ROW: begin
        cfg_row = value[START_ROW_BITS-1:0];
        mask    = 32'h000f_ffff;
      end
      default: begin
        cfg_col = value[START_COL_BITS-1:0];
        mask    = 32'h0000_ffff;
      end
    endcase
    // setup
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    // access
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    reg_writes++;
    @(negedge clk);
    // back-to-back read of the same register
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("register readback", value & mask, prdata & mask);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // receiver stalls at random
  always @(negedge clk) begin
    result_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // every accepted result word against the oldest prediction
  always @(posedge clk) begin
    cursor_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_cursors.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: row %0h column %0h halted %0b",
                   cursor_row, cursor_column, halted);
      end else begin
        want = pending_cursors.pop_front();
        results_checked++;
        check_field("cursor_row", 32'(want.row), 32'(cursor_row));
        check_field("cursor_column", 32'(want.column), 32'(cursor_column));
        check_field("halted", 32'(want.halt), 32'(halted));
      end
    end
  end

  // ---------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------

  // reset config: tab 4, utf8 on, start 0/0
  task automatic test_line_breaks();
    send_word(1'b0, "A");
    send_word(1'b0, CHAR_TAB);
    // cr-lf counts once, lf-cr counts once, lone cr counts
    send_word(1'b0, CHAR_CR);
    send_word(1'b0, CHAR_LF);
    send_word(1'b0, CHAR_LF);
    send_word(1'b0, CHAR_CR);
    send_word(1'b0, CHAR_CR);
    send_word(1'b0, "B");
    // pair swallow is over once another byte came in between
    send_word(1'b0, CHAR_LF);
  endtask

  task automatic test_utf8_sequences();
    // two and four byte characters, one column each
    send_word(1'b0, 8'hc3);
    send_word(1'b0, 8'ha9);
    send_word(1'b0, 8'hf0);
    send_word(1'b0, 8'h9f);
    send_word(1'b0, 8'h98);
    send_word(1'b0, 8'h80);
    // byte order mark and the two noncharacters add nothing
    send_word(1'b0, CHAR_EF);
    send_word(1'b0, CHAR_BB);
    send_word(1'b0, CHAR_BF);
    send_word(1'b0, CHAR_EF);
    send_word(1'b0, CHAR_BF);
    send_word(1'b0, CHAR_BE);
    send_word(1'b0, CHAR_EF);
    send_word(1'b0, CHAR_BF);
    send_word(1'b0, CHAR_BF);
    // any other EF sequence is one column
    send_word(1'b0, CHAR_EF);
    send_word(1'b0, 8'h80);
    send_word(1'b0, 8'h80);
    // stray continuation and invalid lead count one column
    send_word(1'b0, 8'h80);
    send_word(1'b0, 8'hff);
  endtask

  task automatic test_halt_and_restart();
    // zero inside a skip halts, later bytes ignored
    send_word(1'b0, 8'he2);
    send_word(1'b0, 8'h00);
    send_word(1'b0, "A");
    send_word(1'b1, 8'($urandom_range(255)));
  endtask

  task automatic test_encoding_switch_mid_skip();
    send_word(1'b0, 8'he2);
    wait_drained();
    cfg_write(REG_ENCODING, 32'd0);
    // the skip started in utf8 mode still completes
    send_word(1'b0, 8'h82);
    send_word(1'b0, 8'hac);
    // byte mode: EF is just one column
    send_word(1'b0, CHAR_EF);
    wait_drained();
    cfg_write(REG_ENCODING, 32'd1);
  endtask

  task automatic test_tab_zero();
    cfg_write(REG_TAB_SIZE, 32'd0);
    // frozen: not even a zero byte halts
    send_word(1'b0, "A");
    send_word(1'b0, 8'h00);
    send_word(1'b1, 8'($urandom_range(255)));
    wait_drained();
  endtask

  task automatic test_saturation();
    cfg_write(REG_TAB_SIZE, 32'd255);
    cfg_write(REG_START_ROW, 32'(ROW_TOP));
    cfg_write(REG_START_COLUMN, 32'(COL_TOP));
    send_word(1'b1, 8'($urandom_range(255)));
    send_word(1'b0, "Z");
    send_word(1'b0, CHAR_TAB);
    send_word(1'b0, CHAR_CR);
    wait_drained();
  endtask

  // random config per segment, mostly well-formed text with noise mixed in
  task automatic test_random_traffic();
    int target;
    int r;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 8;
          recv_idle_pct = 49;
        end
        1: begin
          send_idle_pct = 49;
          recv_idle_pct = 8;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        // full drain before touching the registers
        wait_drained();
        case ($urandom_range(19))
          0:       cfg_write(REG_TAB_SIZE, 32'd0);
          1, 2:    cfg_write(REG_TAB_SIZE, 32'd1);
          3, 4:    cfg_write(REG_TAB_SIZE, 32'd255);
          5, 6, 7: cfg_write(REG_TAB_SIZE, 32'd4);
          8, 9:    cfg_write(REG_TAB_SIZE, 32'd8);
          default: cfg_write(REG_TAB_SIZE, 32'($urandom_range(255, 1)));
        endcase
        cfg_write(REG_ENCODING, 32'($urandom_range(3) != 0));
        case ($urandom_range(3))
          0:       cfg_write(REG_START_ROW, 32'd0);
          1:       cfg_write(REG_START_ROW, 32'(ROW_TOP) - 32'($urandom_range(3)));
          default: cfg_write(REG_START_ROW, $urandom & 32'h000f_ffff);
        endcase
        case ($urandom_range(3))
          0:       cfg_write(REG_START_COLUMN, 32'd0);
          1:       cfg_write(REG_START_COLUMN, 32'(COL_TOP) - 32'($urandom_range(40)));
          default: cfg_write(REG_START_COLUMN, $urandom & 32'h0000_ffff);
        endcase
        send_word(1'b1, 8'($urandom_range(255)));
        target = words_sent + 128;
        while (words_sent < target) begin
          r = $urandom_range(99);
          if (r < 35) begin
            send_word(1'b0, 8'($urandom_range(126, 32)));
          end else if (r < 45) begin
            send_word(1'b0, $urandom_range(1) ? CHAR_CR : CHAR_LF);
          end else if (r < 52) begin
            if ($urandom_range(1)) begin
              send_word(1'b0, CHAR_CR);
              send_word(1'b0, CHAR_LF);
            end else begin
              send_word(1'b0, CHAR_LF);
              send_word(1'b0, CHAR_CR);
            end
          end else if (r < 58) begin
            send_word(1'b0, CHAR_TAB);
          end else if (r < 68) begin
            send_word(1'b0, 8'($urandom_range(8'hdf, 8'hc2)));
            send_word(1'b0, 8'($urandom_range(255)));
          end else if (r < 76) begin
            send_word(1'b0, 8'($urandom_range(8'hee, 8'he0)));
            repeat (2) send_word(1'b0, 8'($urandom_range(255)));
          end else if (r < 82) begin
            send_word(1'b0, 8'($urandom_range(8'hf4, 8'hf0)));
            repeat (3) send_word(1'b0, 8'($urandom_range(255)));
          end else if (r < 88) begin
            send_word(1'b0, CHAR_EF);
            case ($urandom_range(3))
              0: begin
                send_word(1'b0, CHAR_BB);
                send_word(1'b0, CHAR_BF);
              end
              1: begin
                send_word(1'b0, CHAR_BF);
                send_word(1'b0, CHAR_BE);
              end
              2: begin
                send_word(1'b0, CHAR_BF);
                send_word(1'b0, CHAR_BF);
              end
              default: begin
                send_word(1'b0, 8'($urandom_range(255)));
                send_word(1'b0, 8'($urandom_range(255)));
              end
            endcase
          end else if (r < 94) begin
            // raw noise, zero included
            send_word(1'b0, 8'($urandom_range(255)));
          end else if (r < 97) begin
            // terminator, mostly followed by a restart so tracking resumes
            send_word(1'b0, 8'h00);
            if ($urandom_range(9) != 0) send_word(1'b1, 8'($urandom_range(255)));
          end else begin
            send_word(1'b1, 8'($urandom_range(255)));
          end
        end
      end
    end
  endtask

  // ---------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------

  initial begin
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    item_valid      = 1'b0;
    action          = 1'b0;
    data_byte       = 8'h00;
    mismatches      = 0;
    words_sent      = 0;
    results_checked = 0;
    reg_writes      = 0;
    send_idle_pct   = 8;
    recv_idle_pct   = 49;
    // reset values of the config registers
    cfg_tab  = TAB_SIZE_RST;
    cfg_utf8 = ENCODING_RST;
    cfg_row  = START_ROW_RST;
    cfg_col  = START_COLUMN_RST;
    restart_cursor();
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_line_breaks();
    test_utf8_sequences();
    test_halt_and_restart();
    test_encoding_switch_mid_skip();
    test_tab_zero();
    test_saturation();
    test_random_traffic();
    wait_drained();

    $display("covered %0d input words (%0d results checked) over %0d register writes,",
             words_sent, results_checked, reg_writes);
    $display("line breaks, tabs, utf8 skips, halts, restarts and saturation under stalls");
    if (mismatches == 0) begin
      $display("text_cursor_row_column_tracker_unit_test passed");
    end else begin
      $display("text_cursor_row_column_tracker_unit_test failed");
    end
    $finish;
  end

endmodule
